FILE: hdl/aob_pkg.sv
// ---------------------------------------------------------------------------
// Alpha overlay blend package
// Shared widths, register indexes and channel payload types.
// ---------------------------------------------------------------------------
package aob_pkg;

    localparam int COORD_BITS = 12;
    localparam int CFG_W      = 13;
    localparam int CNT_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int PIX_W      = 8;
    localparam int PROD_W     = 2 * PIX_W;
    localparam int CH_NUM     = 4;
    localparam int DX_W       = ((COORD_BITS > CFG_W) ? COORD_BITS : CFG_W) + 2;

    localparam logic [PIX_W-1:0] PIX_MAX   = '1;
    localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(3);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_X      = 3'd0,
        REG_WINDOW_Y      = 3'd1,
        REG_FG_WIDTH      = 3'd2,
        REG_FG_HEIGHT     = 3'd3,
        REG_CHANNEL_COUNT = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] pix_col;
        logic [COORD_BITS-1:0] pix_row;
        logic [PIX_W-1:0]      bg_c0;
        logic [PIX_W-1:0]      bg_c1;
        logic [PIX_W-1:0]      bg_c2;
        logic [PIX_W-1:0]      bg_c3;
        logic [PIX_W-1:0]      fg_c0;
        logic [PIX_W-1:0]      fg_c1;
        logic [PIX_W-1:0]      fg_c2;
        logic [PIX_W-1:0]      fg_alpha;
    } pix_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] out_c0;
        logic [PIX_W-1:0] out_c1;
        logic [PIX_W-1:0] out_c2;
        logic [PIX_W-1:0] out_c3;
        logic             blended;
    } res_t;

endpackage

FILE: hdl/aob_pix_if.sv
// ---------------------------------------------------------------------------
// Pixel input channel
// Valid/ready channel carrying one background pixel and its foreground pixel.
// ---------------------------------------------------------------------------
interface aob_pix_if;
    import aob_pkg::*;

    logic    valid;
    logic    ready;
    pix_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

FILE: hdl/aob_res_if.sv
// ---------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one composited pixel.
// ---------------------------------------------------------------------------
interface aob_res_if;
    import aob_pkg::*;

    logic valid;
    logic ready;
    res_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

FILE: hdl/alpha_overlay_blend_unit.sv
// ---------------------------------------------------------------------------
// Alpha overlay blend unit
// Composites a foreground RGBA pixel over a background pixel inside a
// configurable window using the 8-bit over operator.
// ---------------------------------------------------------------------------
//  channel   direction  handshake       payload
//  pix       in         valid / ready   position, bg_c0..3, fg_c0..2, fg_alpha
//  res       out        valid / ready   out_c0..3, blended
//  cfg       in         cfg_we          cfg_idx, cfg_wdata (13 bits)
//
//  Three register stages: window test, lane products, divide and select.
//  One pixel per cycle while res.ready is high; registered in stages A, B and C.
//  Each stage holds while the stage after it is full and stalled; ready
//  ripples back from the output register, so bubbles are squeezed out.
//  rst_n clears the valid bits and loads the register reset values.
// ---------------------------------------------------------------------------
module alpha_overlay_blend_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [aob_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [aob_pkg::CFG_W-1:0]    cfg_wdata,
    aob_pix_if.sink                      pix,
    aob_res_if.source                    res
);
    import aob_pkg::*;

    function automatic logic [PIX_W-1:0] div255(input logic [PROD_W-1:0] s);
        logic [PROD_W-1:0] t;
        t = s + {{PIX_W{1'b0}}, s[PROD_W-1:PIX_W]} + PROD_W'(1);
        return t[PROD_W-1:PIX_W];
    endfunction

    // configuration registers
    logic signed [CFG_W-1:0] win_x_reg;
    logic signed [CFG_W-1:0] win_y_reg;
    logic [CFG_W-1:0]        fg_w_reg;
    logic [CFG_W-1:0]        fg_h_reg;
    logic [CNT_W-1:0]        ch_cnt_reg;

    // stage A: window test
    logic                    a_valid_reg;
    logic                    a_blend_reg;
    logic [PIX_W-1:0]        a_alpha_reg;
    logic [PIX_W-1:0]        a_bg_reg [CH_NUM];
    logic [PIX_W-1:0]        a_fg_reg [CH_NUM];
    logic                    a_blend_next;
    logic [PIX_W-1:0]        a_bg_next [CH_NUM];
    logic [PIX_W-1:0]        a_fg_next [CH_NUM];
    logic signed [DX_W-1:0]  dx;
    logic signed [DX_W-1:0]  dy;
    logic                    in_x;
    logic                    in_y;

    // stage B: products
    logic                    b_valid_reg;
    logic                    b_blend_reg;
    logic [PIX_W-1:0]        b_bg_reg [CH_NUM];
    logic [PIX_W-1:0]        b_fg_reg [CH_NUM];
    logic [PROD_W-1:0]       b_pbg_reg [CH_NUM];
    logic [PROD_W-1:0]       b_pfg_reg [CH_NUM];
    logic [PROD_W-1:0]       b_pbg_next [CH_NUM];
    logic [PROD_W-1:0]       b_pfg_next [CH_NUM];

    // stage C: output register
    logic                    res_valid_reg;
    res_t                    res_reg;
    res_t                    res_next;
    logic [PIX_W-1:0]        lane_out [CH_NUM];

    logic                    a_rdy;
    logic                    b_rdy;
    logic                    c_rdy;

    assign c_rdy = !res_valid_reg || res.ready;
    assign b_rdy = !b_valid_reg || c_rdy;
    assign a_rdy = !a_valid_reg || b_rdy;

    assign pix.ready = a_rdy;
    assign res.valid = res_valid_reg;
    assign res.data  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_x_reg  <= '0;
            win_y_reg  <= '0;
            fg_w_reg   <= '0;
            fg_h_reg   <= '0;
            ch_cnt_reg <= CNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_idx))
                REG_WINDOW_X:      win_x_reg  <= $signed(cfg_wdata);
                REG_WINDOW_Y:      win_y_reg  <= $signed(cfg_wdata);
                REG_FG_WIDTH:      fg_w_reg   <= cfg_wdata;
                REG_FG_HEIGHT:     fg_h_reg   <= cfg_wdata;
                REG_CHANNEL_COUNT: ch_cnt_reg <= cfg_wdata[CNT_W-1:0];
                default:           ;
            endcase
        end
    end

    // window test on the incoming pixel
    always_comb
    begin
        dx   = $signed(DX_W'(pix.data.pix_col)) - DX_W'(win_x_reg);
        dy   = $signed(DX_W'(pix.data.pix_row)) - DX_W'(win_y_reg);
        in_x = !dx[DX_W-1] && ($unsigned(dx) < DX_W'(fg_w_reg));
        in_y = !dy[DX_W-1] && ($unsigned(dy) < DX_W'(fg_h_reg));
        a_blend_next = in_x && in_y && (pix.data.fg_alpha != '0);
        a_bg_next[0] = pix.data.bg_c0;
        a_bg_next[1] = pix.data.bg_c1;
        a_bg_next[2] = pix.data.bg_c2;
        a_bg_next[3] = pix.data.bg_c3;
        a_fg_next[0] = pix.data.fg_c0;
        a_fg_next[1] = pix.data.fg_c1;
        a_fg_next[2] = pix.data.fg_c2;
        a_fg_next[3] = pix.data.fg_alpha;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (a_rdy)
            a_valid_reg <= pix.valid;
    end

    always_ff @(posedge clk)
    begin
        if (a_rdy && pix.valid)
        begin
            a_blend_reg <= a_blend_next;
            a_alpha_reg <= pix.data.fg_alpha;
            a_bg_reg    <= a_bg_next;
            a_fg_reg    <= a_fg_next;
        end
    end

    // lane products
    always_comb
    begin
        for (int c = 0; c < CH_NUM; c++)
        begin
            b_pbg_next[c] = PROD_W'(a_bg_reg[c]) * PROD_W'(PIX_MAX - a_alpha_reg);
            b_pfg_next[c] = PROD_W'(a_fg_reg[c]) * PROD_W'(a_alpha_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (b_rdy)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (b_rdy && a_valid_reg)
        begin
            b_blend_reg <= a_blend_reg;
            b_bg_reg    <= a_bg_reg;
            b_fg_reg    <= a_fg_reg;
            b_pbg_reg   <= b_pbg_next;
            b_pfg_reg   <= b_pfg_next;
        end
    end

    // divide by 255, pass through or drop inactive channels
    always_comb
    begin
        for (int c = 0; c < CH_NUM; c++)
        begin
            if (CNT_W'(c) >= ch_cnt_reg)
                lane_out[c] = '0;
            else if (b_blend_reg)
                lane_out[c] = div255(b_pbg_reg[c] + b_pfg_reg[c]);
            else
                lane_out[c] = b_bg_reg[c];
        end
        res_next.out_c0  = lane_out[0];
        res_next.out_c1  = lane_out[1];
        res_next.out_c2  = lane_out[2];
        res_next.out_c3  = lane_out[3];
        res_next.blended = b_blend_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (c_rdy)
            res_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (c_rdy && b_valid_reg)
            res_reg <= res_next;
    end

`ifndef NO_ASSERTIONS
    a_b_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && !c_rdy |=> b_valid_reg && $stable(b_bg_reg[0]) && $stable(b_blend_reg))
        else $error("stage B lost or changed its pixel during a stall");

    a_blend_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && c_rdy && b_blend_reg && (ch_cnt_reg != '0) |=>
        ($past(b_bg_reg[0]) <= res.data.out_c0 || $past(b_fg_reg[0]) <= res.data.out_c0) &&
        ($past(b_bg_reg[0]) >= res.data.out_c0 || $past(b_fg_reg[0]) >= res.data.out_c0))
        else $error("blended channel 0 outside background and foreground range");

    a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && c_rdy && !b_blend_reg && (ch_cnt_reg != '0) |=>
        res.data.out_c0 == $past(b_bg_reg[0]) && !res.data.blended)
        else $error("unblended pixel did not pass the background through");

    a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && b_valid_reg && res_valid_reg && !res.ready |-> !pix.ready)
        else $error("transfer accepted with the pipeline full and stalled");
`endif

endmodule
